### rtl/lsf_pkg.sv
// Shared types and constants for the least-squares line fit store.
// Command/result transfer structs, opcode and status codes, sequencer enums.
// No dependencies.
`timescale 1ns / 1ps

package lsf_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int COUNT_W     = 9;
	localparam int SMP_W       = 16;
	localparam int SUM_W       = 25;
	localparam int SQ_W        = 40;
	localparam int MUL_A_W     = 49;
	localparam int MUL_B_W     = 26;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int DVS_W       = 56;
	localparam int QUO_W       = 16;
	localparam int DCNT_W      = $clog2(QUO_W);

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_PRED_Y = 3'd3,
		OP_PRED_X = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOFIT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_FIND,
		S_MUL,
		S_DIV_SAT,
		S_DIV,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		STEP_NXY,
		STEP_TXTY,
		STEP_NXX,
		STEP_TXTX,
		STEP_NQ,
		STEP_T0,
		STEP_T1,
		STEP_DVS,
		STEP_SQXY,
		STEP_SQXX
	} step_t;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [SMP_W-1:0] sample_x;
		logic signed [SMP_W-1:0] sample_y;
		logic signed [SMP_W-1:0] query_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [QUO_W-1:0]   prediction;
		logic [COUNT_W-1:0] sample_count;
	} res_t;

endpackage

### rtl/lsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lsf_mul.sv
// Shared shift-add signed multiplier, one multiplier bit per cycle.
// Depends on lsf_pkg for operand and product widths.
`timescale 1ns / 1ps

module lsf_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [lsf_pkg::MUL_A_W-1:0]   a,
	input  logic signed [lsf_pkg::MUL_B_W-1:0]   b,
	output logic                                 done,
	output logic signed [lsf_pkg::MUL_P_W-1:0]   product
);

	import lsf_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MUL_P_W-2:0] a_sh_q;
	logic [MUL_B_W-1:0] b_sh_q;
	logic [MUL_P_W-2:0] acc_q;
	logic               neg_q;
	logic [MUL_A_W-1:0] a_mag;
	logic [MUL_B_W-1:0] b_mag;
	logic [MUL_P_W-1:0] prod_mag;

	// operand magnitudes
	assign a_mag = a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
	assign b_mag = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);

	// control: busy for one cycle per multiplier bit, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: add shifted multiplicand when the current multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= (MUL_P_W-1)'(a_mag);
			b_sh_q <= b_mag;
			acc_q  <= '0;
			neg_q  <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
		end else if (busy_q) begin
			if (b_sh_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
		end
	end

	// restore the sign
	assign prod_mag = {1'b0, acc_q};
	assign product  = neg_q ? $signed(-prod_mag) : $signed(prod_mag);
	assign done     = done_q;

endmodule

### rtl/least_squares_line_fit_store.sv
// Top level of the least-squares line fit store: sequencer, sample table,
// running sums, fit evaluation and restoring divider.
// Depends on lsf_pkg, lsf_ram and lsf_mul.
`timescale 1ns / 1ps

// Usage:
// Commands arrive on cmd/cmd_valid/cmd_stall, one result per command leaves on
// res/res_valid/res_stall. A transfer happens when valid is high and stall low.
// The block works on one command at a time and holds cmd_stall high until the
// command's result is loaded into the output register; the next command may
// then enter while that result still waits for the receiver.
// Work per command, done by the slot scan and the shared shift-add multiplier:
//   add:            lowest-free-slot scan, 1 slot per cycle (up to 256), plus
//                   two multiplies; none of this when the table is full
//   remove:         match scan through the RAM, 1 slot per cycle, plus two
//                   multiplies when a sample is removed
//   find:           the same match scan as remove, with no multiplies
//   predict:        eight multiplies and a 16-step divide, cut short on no fit or a saturated quotient
//   unused opcodes: no work, straight to the result
// Reset clears the slot valid bits, count and sums at once; the sample RAM
// needs no clearing since only valid slots are ever compared.
// While res_stall is high a result waits in the output register; the block can
// still take a further command, whose result then waits in the block.

module least_squares_line_fit_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lsf_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output lsf_pkg::res_t res
);

	import lsf_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SAMPLES - 1);

	state_t                    state_q, state_d;
	step_t                     step_q;
	logic [MAX_SAMPLES-1:0]    valid_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0]   tx_q, ty_q;
	logic signed [SQ_W-1:0]    txy_q, txx_q;
	logic                      issued_q;
	logic                      cmp_live_s1;
	logic [IDX_W-1:0]          cmp_idx_s1;
	logic [IDX_W-1:0]          scan_q;
	logic                      res_valid_q;
	res_t                      res_q;

	logic [2:0]                op_q;
	logic signed [SMP_W-1:0]   x_q, y_q, q_q;
	logic [1:0]                stat_q;
	logic                      found_q;
	logic [QUO_W-1:0]          pred_q;
	logic signed [MUL_A_W-1:0] num_q, den_q;
	logic signed [MUL_B_W-1:0] diff_q;
	logic signed [MUL_P_W-1:0] t_q;
	logic [DVS_W-1:0]          dvs_q;
	logic [MUL_P_W-1:0]        r_q, dsh_q;
	logic [QUO_W-1:0]          quo_q;
	logic [DCNT_W-1:0]         dcnt_q;

	logic                      cmd_acc;
	logic                      res_free;
	logic                      ram_we;
	logic [2*SMP_W-1:0]        ram_rdata;
	logic                      smp_match;
	logic                      hit, miss, free_hit;
	logic                      is_full;
	logic                      mul_start, mul_done;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic [MUL_P_W-1:0]        prod_mag, t_mag;
	logic signed [MUL_A_W-1:0] den_new;
	logic                      nofit;
	logic                      div_sat, div_ge, div_last;
	logic [QUO_W-1:0]          quo_next;

	// sample table, x in the upper half and y in the lower half of each word
	lsf_ram #(
		.WIDTH (2 * SMP_W),
		.DEPTH (MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scan_q),
		.wdata ({x_q, y_q}),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	// shared multiplier
	lsf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	// status decode
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign is_full   = count_q >= COUNT_W'(MAX_SAMPLES);
	assign smp_match = ram_rdata == {x_q, y_q};
	assign hit       = cmp_live_s1 && valid_q[cmp_idx_s1] && smp_match;
	assign miss      = cmp_live_s1 && !hit && (cmp_idx_s1 == LAST_IDX);
	assign free_hit  = (state_q == S_FREE) && !valid_q[scan_q];
	assign prod_mag  = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
	assign t_mag     = t_q[MUL_P_W-1] ? MUL_P_W'(-t_q) : MUL_P_W'(t_q);
	assign den_new   = den_q - prod[MUL_A_W-1:0];
	assign nofit     = (den_new == '0) || ((op_q == OP_PRED_X) && (num_q == '0));
	assign div_sat   = r_q >= MUL_P_W'({dvs_q, {QUO_W{1'b0}}});
	assign div_ge    = r_q >= dsh_q;
	assign div_last  = dcnt_q == DCNT_W'(QUO_W - 1);
	assign quo_next  = {quo_q[QUO_W-2:0], div_ge};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.opcode) inside
						OP_ADD:            state_d = is_full ? S_FINISH : S_FREE;
						OP_REMOVE, OP_FIND: state_d = S_FIND;
						OP_PRED_Y, OP_PRED_X: state_d = S_MUL;
						default:           state_d = S_FINISH;
					endcase
				end
			end
			S_FREE: begin
				if (free_hit) state_d = S_MUL;
			end
			S_FIND: begin
				if (hit) begin
					state_d = (op_q == OP_REMOVE) ? S_MUL : S_FINISH;
				end else if (miss) begin
					state_d = S_FINISH;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					case (step_q)
						STEP_TXTY: state_d = S_MUL;
						STEP_TXTX: state_d = nofit ? S_FINISH : S_MUL;
						STEP_DVS:  state_d = S_DIV_SAT;
						STEP_SQXX: state_d = S_FINISH;
						default:   state_d = S_MUL;
					endcase
				end
			end
			S_DIV_SAT: state_d = div_sat ? S_FINISH : S_DIV;
			S_DIV: begin
				if (div_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (res_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_stall = state_q != S_IDLE;
		mul_start = (state_q == S_MUL) && !issued_q;
		ram_we    = free_hit;
	end

	// multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			STEP_NXY: begin
				mul_a = MUL_A_W'(txy_q);
				mul_b = MUL_B_W'(count_q);
			end
			STEP_TXTY: begin
				mul_a = MUL_A_W'(tx_q);
				mul_b = MUL_B_W'(ty_q);
			end
			STEP_NXX: begin
				mul_a = MUL_A_W'(txx_q);
				mul_b = MUL_B_W'(count_q);
			end
			STEP_TXTX: begin
				mul_a = MUL_A_W'(tx_q);
				mul_b = MUL_B_W'(tx_q);
			end
			STEP_NQ: begin
				mul_a = MUL_A_W'(q_q);
				mul_b = MUL_B_W'(count_q);
			end
			STEP_T0: begin
				mul_a = den_q;
				mul_b = (op_q == OP_PRED_Y) ? MUL_B_W'(ty_q) : diff_q;
			end
			STEP_T1: begin
				mul_a = num_q;
				mul_b = (op_q == OP_PRED_Y) ? diff_q : MUL_B_W'(tx_q);
			end
			STEP_DVS: begin
				mul_a = (op_q == OP_PRED_Y) ? den_q : num_q;
				mul_b = MUL_B_W'(count_q);
			end
			STEP_SQXY: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(y_q);
			end
			STEP_SQXX: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(x_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control state: slot valid bits, count, running sums, handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			count_q     <= '0;
			tx_q        <= '0;
			ty_q        <= '0;
			txy_q       <= '0;
			txx_q       <= '0;
			issued_q    <= 1'b0;
			cmp_live_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmp_live_s1 <= (state_q == S_FIND) && !hit && !miss;

			// one multiply in flight at a time
			if (mul_start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end

			// claim the lowest free slot
			if (free_hit) begin
				valid_q[scan_q] <= 1'b1;
				count_q         <= count_q + 1'b1;
				tx_q            <= tx_q + SUM_W'(x_q);
				ty_q            <= ty_q + SUM_W'(y_q);
			end

			// drop the first matching sample
			if (hit && (op_q == OP_REMOVE)) begin
				valid_q[cmp_idx_s1] <= 1'b0;
				count_q             <= count_q - 1'b1;
				tx_q                <= tx_q - SUM_W'(x_q);
				ty_q                <= ty_q - SUM_W'(y_q);
			end

			// fold the product sums
			if ((state_q == S_MUL) && mul_done) begin
				case (step_q)
					STEP_SQXY: begin
						txy_q <= (op_q == OP_REMOVE) ? txy_q - prod[SQ_W-1:0]
						                             : txy_q + prod[SQ_W-1:0];
					end
					STEP_SQXX: begin
						txx_q <= (op_q == OP_REMOVE) ? txx_q - prod[SQ_W-1:0]
						                             : txx_q + prod[SQ_W-1:0];
					end
					default: ;
				endcase
			end

			// result register valid
			if ((state_q == S_FINISH) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					op_q    <= cmd.opcode;
					x_q     <= cmd.sample_x;
					y_q     <= cmd.sample_y;
					q_q     <= cmd.query_value;
					stat_q  <= ((cmd.opcode == OP_ADD) && is_full) ? ST_FULL : ST_OK;
					found_q <= 1'b0;
					pred_q  <= '0;
					scan_q  <= '0;
					step_q  <= STEP_NXY;
				end
			end
			S_FREE: begin
				if (free_hit) begin
					step_q <= STEP_SQXY;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			S_FIND: begin
				scan_q     <= scan_q + 1'b1;
				cmp_idx_s1 <= scan_q;
				if (hit) begin
					found_q <= 1'b1;
					step_q  <= STEP_SQXY;
				end else if (miss) begin
					stat_q <= ST_MISSING;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					case (step_q)
						STEP_NXY: begin
							num_q  <= prod[MUL_A_W-1:0];
							step_q <= STEP_TXTY;
						end
						STEP_TXTY: begin
							num_q  <= num_q - prod[MUL_A_W-1:0];
							step_q <= STEP_NXX;
						end
						STEP_NXX: begin
							den_q  <= prod[MUL_A_W-1:0];
							step_q <= STEP_TXTX;
						end
						STEP_TXTX: begin
							den_q  <= den_new;
							step_q <= STEP_NQ;
							if (nofit) stat_q <= ST_NOFIT;
						end
						STEP_NQ: begin
							diff_q <= prod[MUL_B_W-1:0] - ((op_q == OP_PRED_Y)
							          ? MUL_B_W'(tx_q) : MUL_B_W'(ty_q));
							step_q <= STEP_T0;
						end
						STEP_T0: begin
							t_q    <= prod;
							step_q <= STEP_T1;
						end
						STEP_T1: begin
							t_q    <= t_q + prod;
							step_q <= STEP_DVS;
						end
						STEP_DVS: begin
							dvs_q <= prod_mag[DVS_W-1:0];
							r_q   <= t_mag;
						end
						STEP_SQXY: step_q <= STEP_SQXX;
						default: ;
					endcase
				end
			end
			S_DIV_SAT: begin
				// quotient of 2^16 or more saturates
				if (div_sat) begin
					pred_q <= '1;
				end
				dsh_q  <= MUL_P_W'({dvs_q, {(QUO_W-1){1'b0}}});
				dcnt_q <= '0;
				quo_q  <= '0;
			end
			S_DIV: begin
				// one restoring step per cycle, most significant bit first
				if (div_ge) begin
					r_q <= r_q - dsh_q;
				end
				quo_q  <= quo_next;
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q + 1'b1;
				if (div_last) pred_q <= quo_next;
			end
			S_FINISH: begin
				if (res_free) begin
					res_q.status       <= stat_q;
					res_q.found        <= found_q;
					res_q.prediction   <= pred_q;
					res_q.sample_count <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
